>>> hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the reverse Polish stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int VALUE_W             = 48;
   localparam int MODE_W              = 3;
   localparam int STATUS_W            = 3;
   localparam int STACK_DEPTH_DEF     = 32;
   localparam int FRACTION_BITS_DEF   = 16;

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BAD     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FINISH  = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FEW_OPS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXTRA     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_BAD,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } token_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } muldiv_ctrl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WAIT
   } back_state_type;

endpackage

>>> hdl/rpn_if.sv
// ----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels for requests and responses of the evaluator.
// ----------------------------------------------------------------------------
interface rpn_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [47:0] token_value;

   modport source (output valid, output mode, output token_value, input ready);
   modport sink   (input valid, input mode, input token_value, output ready);
endinterface

interface rpn_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [47:0] result_value;
   logic               finished;

   modport source (output valid, output status, output result_value, output finished,
                   input ready);
   modport sink   (input valid, input status, input result_value, input finished,
                   output ready);
endinterface

>>> hdl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front
// Accepts requests, classifies the mode and queues tokens (two entries).
// ----------------------------------------------------------------------------
module rpn_front (
   input  logic               clock,
   input  logic               reset,
   rpn_req_if.sink            req_chan,
   output rpn_pkg::token_type tok,
   output logic               tok_valid,
   input  logic               tok_pop
);
   import rpn_pkg::*;

   token_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   op_type     op_cls;

   always_comb begin
      unique case (req_chan.mode)
         MODE_PUSH:   op_cls = OP_PUSH;
         MODE_ADD:    op_cls = OP_ADD;
         MODE_SUB:    op_cls = OP_SUB;
         MODE_MUL:    op_cls = OP_MUL;
         MODE_DIV:    op_cls = OP_DIV;
         MODE_FINISH: op_cls = OP_FINISH;
         default:     op_cls = OP_BAD;
      endcase
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push      = req_chan.valid && req_chan.ready;
   assign tok_valid = (cnt_ff != 2'd0);
   assign pop       = tok_pop && tok_valid;
   assign tok       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op_cls, value: req_chan.token_value};
      end
   end
endmodule

>>> hdl/rpn_muldiv.sv
// ----------------------------------------------------------------------------
// rpn_muldiv
// Iterative fixed point multiply (16-bit slices) and restoring divide
// (one quotient bit per cycle), signed and saturating.
// ----------------------------------------------------------------------------
module rpn_muldiv #(
   parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rpn_pkg::muldiv_ctrl_type        ctrl,
   input  logic signed [rpn_pkg::VALUE_W-1:0] op_a,
   input  logic signed [rpn_pkg::VALUE_W-1:0] op_b,
   output logic                            done,
   output logic signed [rpn_pkg::VALUE_W-1:0] result
);
   import rpn_pkg::*;

   localparam int SLICE_W  = 16;
   localparam int SLICES   = VALUE_W / SLICE_W;
   localparam int PROD_W   = 2 * VALUE_W;
   localparam int NUM_W    = VALUE_W + FRACTION_BITS;
   localparam int STEP_W   = $clog2(NUM_W + 1);

   logic [VALUE_W-1:0]  ma_ff, mb_ff;
   logic                neg_ff, is_div_ff, busy_ff, done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [VALUE_W-1:0]  rem_ff;
   logic [NUM_W-1:0]    quo_ff;

   logic [VALUE_W-1:0]         mag_a, mag_b;
   logic [VALUE_W+SLICE_W-1:0] partial;
   logic [VALUE_W:0]           rem_sh, rem_sub;
   logic                       q_bit;
   logic                       last;
   logic [PROD_W-1:0]          mag;
   logic                       big;
   logic signed [VALUE_W-1:0]  sat;

   assign mag_a   = op_a[VALUE_W-1] ? VALUE_W'(-op_a) : VALUE_W'(op_a);
   assign mag_b   = op_b[VALUE_W-1] ? VALUE_W'(-op_b) : VALUE_W'(op_b);
   assign partial = ma_ff * mb_ff[step_ff[1:0]*SLICE_W +: SLICE_W];
   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, mb_ff};
   assign q_bit   = !rem_sub[VALUE_W];
   assign last    = is_div_ff ? (step_ff == STEP_W'(NUM_W - 1))
                              : (step_ff == STEP_W'(SLICES - 1));

   // saturate the finished magnitude once the unit has gone idle
   always_comb begin
      mag = is_div_ff ? PROD_W'(quo_ff) : (acc_ff >> FRACTION_BITS);
      big = |mag[PROD_W-1:VALUE_W-1];
      if (neg_ff) begin
         sat = big ? VALUE_MIN : -$signed(mag[VALUE_W-1:0]);
      end else begin
         sat = big ? VALUE_MAX : $signed(mag[VALUE_W-1:0]);
      end
   end

   // done stays high from completion until the next start
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         ma_ff     <= mag_a;
         mb_ff     <= mag_b;
         neg_ff    <= op_a[VALUE_W-1] ^ op_b[VALUE_W-1];
         is_div_ff <= ctrl.is_div;
         step_ff   <= '0;
         acc_ff    <= '0;
         rem_ff    <= '0;
         quo_ff    <= NUM_W'(mag_a) << FRACTION_BITS;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (is_div_ff) begin
            rem_ff <= q_bit ? rem_sub[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], q_bit};
         end else begin
            acc_ff <= acc_ff + (PROD_W'(partial) << (step_ff[1:0] * SLICE_W));
         end
      end
   end

   assign done   = done_ff;
   assign result = sat;
endmodule

>>> hdl/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back
// Executes queued tokens against the operand stack and drives responses.
// The top of stack is also held in a register; every entry lives in RAM.
// ----------------------------------------------------------------------------
module rpn_back #(
   parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  rpn_pkg::token_type tok,
   input  logic               tok_valid,
   output logic               tok_pop,
   rpn_rsp_if.source          rsp_chan
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   back_state_type            state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [STATUS_W-1:0]       err_ff, err_in;
   logic signed [VALUE_W-1:0] tos_ff, tos_in;
   op_type                    op_ff, op_in;

   logic                      out_v_ff, out_v_in;
   logic [STATUS_W-1:0]       out_st_ff, out_st_in;
   logic signed [VALUE_W-1:0] out_val_ff, out_val_in;
   logic                      out_fin_ff, out_fin_in;

   logic                      we;
   logic [AW-1:0]             waddr, raddr;
   logic signed [VALUE_W-1:0] wdata, rdata;
   logic [CW-1:0]             cnt_m2;

   muldiv_ctrl_type           md_ctrl;
   logic                      md_done;
   logic signed [VALUE_W-1:0] md_result;

   logic                      out_free;
   logic signed [VALUE_W:0]   addsub;
   logic signed [VALUE_W-1:0] addsub_sat;
   logic signed [VALUE_W-1:0] top_or_zero;

   rpn_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   rpn_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .op_a   (rdata),
      .op_b   (tos_ff),
      .done   (md_done),
      .result (md_result)
   );

   assign cnt_m2      = cnt_ff - CW'(2);
   assign out_free    = !out_v_ff || rsp_chan.ready;
   assign top_or_zero = (cnt_ff != '0) ? tos_ff : '0;

   always_comb begin
      if (op_ff == OP_SUB) begin
         addsub = {rdata[VALUE_W-1], rdata} - {tos_ff[VALUE_W-1], tos_ff};
      end else begin
         addsub = {rdata[VALUE_W-1], rdata} + {tos_ff[VALUE_W-1], tos_ff};
      end
      if (addsub[VALUE_W] != addsub[VALUE_W-1]) begin
         addsub_sat = addsub[VALUE_W] ? VALUE_MIN : VALUE_MAX;
      end else begin
         addsub_sat = addsub[VALUE_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      err_in     = err_ff;
      tos_in     = tos_ff;
      op_in      = op_ff;
      out_v_in   = out_v_ff && !rsp_chan.ready;
      out_st_in  = out_st_ff;
      out_val_in = out_val_ff;
      out_fin_in = out_fin_ff;
      tok_pop    = 1'b0;
      we         = 1'b0;
      waddr      = cnt_ff[AW-1:0];
      wdata      = tok.value;
      raddr      = cnt_m2[AW-1:0];
      md_ctrl    = '{start: 1'b0, is_div: (op_ff == OP_DIV)};

      unique case (state_ff)
         S_IDLE: begin
            if (tok_valid && out_free) begin
               tok_pop    = 1'b1;
               out_v_in   = 1'b1;
               out_fin_in = 1'b0;
               out_val_in = top_or_zero;
               if (tok.op == OP_FINISH) begin
                  out_fin_in = 1'b1;
                  out_val_in = '0;
                  if (err_ff != ST_OK) begin
                     out_st_in = err_ff;
                  end else if (cnt_ff == '0) begin
                     out_st_in = ST_EMPTY;
                  end else if (cnt_ff != CW'(1)) begin
                     out_st_in = ST_EXTRA;
                  end else begin
                     out_st_in  = ST_OK;
                     out_val_in = tos_ff;
                  end
                  cnt_in = '0;
                  err_in = ST_OK;
               end else if (err_ff != ST_OK) begin
                  out_st_in = err_ff;
               end else if (tok.op == OP_PUSH) begin
                  if (cnt_ff == CW'(STACK_DEPTH)) begin
                     err_in    = ST_OVERFLOW;
                     out_st_in = ST_OVERFLOW;
                  end else begin
                     we         = 1'b1;
                     tos_in     = tok.value;
                     cnt_in     = cnt_ff + CW'(1);
                     out_st_in  = ST_OK;
                     out_val_in = tok.value;
                  end
               end else if (cnt_ff < CW'(2)) begin
                  err_in    = ST_FEW_OPS;
                  out_st_in = ST_FEW_OPS;
               end else if (tok.op == OP_BAD) begin
                  err_in    = ST_UNKNOWN;
                  out_st_in = ST_UNKNOWN;
               end else if (tok.op == OP_DIV && tos_ff == '0) begin
                  err_in    = ST_DIV_ZERO;
                  out_st_in = ST_DIV_ZERO;
               end else begin
                  // operator: fetch the first operand, answer later
                  out_v_in = out_v_ff && !rsp_chan.ready;
                  op_in    = tok.op;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               // read address is unchanged while waiting, so rdata holds
               if (out_free) begin
                  we         = 1'b1;
                  waddr      = cnt_m2[AW-1:0];
                  wdata      = addsub_sat;
                  tos_in     = addsub_sat;
                  cnt_in     = cnt_ff - CW'(1);
                  out_v_in   = 1'b1;
                  out_st_in  = ST_OK;
                  out_val_in = addsub_sat;
                  out_fin_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end else begin
               md_ctrl.start = 1'b1;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (md_done && out_free) begin
               we         = 1'b1;
               waddr      = cnt_m2[AW-1:0];
               wdata      = md_result;
               tos_in     = md_result;
               cnt_in     = cnt_ff - CW'(1);
               out_v_in   = 1'b1;
               out_st_in  = ST_OK;
               out_val_in = md_result;
               out_fin_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         err_ff   <= ST_OK;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff     <= tos_in;
      op_ff      <= op_in;
      out_st_ff  <= out_st_in;
      out_val_ff <= out_val_in;
      out_fin_ff <= out_fin_in;
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.status       = out_st_ff;
   assign rsp_chan.result_value = out_val_ff;
   assign rsp_chan.finished     = out_fin_ff;
endmodule

>>> hdl/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Reverse Polish evaluator over classified tokens, Q31.16 saturating values.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one token per request (mode, token_value); rsp_chan
//   returns exactly one response per request (status, result_value,
//   finished), in order. Both are valid/ready channels.
//   A two-entry token queue sits between the front end and the executing
//   back end, so requests are taken while the back end is busy.
//   Per token: push, finish and error tokens are answered straight from
//   the idle state; add and subtract take one stack RAM read; multiply
//   runs three 48x16 slices; divide computes VALUE_W + FRACTION_BITS
//   quotient bits (one quotient bit per cycle). The back end runs one token
//   at a time and takes no new token until the current one is answered.
//   Reset (synchronous) empties the stack, clears any error and drops
//   queued tokens. Stack RAM contents are not cleared.
//   If rsp_chan is stalled the response is held in its output register;
//   the back end finishes any operation under way and then waits, the
//   queue fills and req_chan.ready deasserts.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rpn_req_if.sink  req_chan,
   rpn_rsp_if.source rsp_chan
);
   import rpn_pkg::*;

   token_type tok;
   logic      tok_valid;
   logic      tok_pop;

   rpn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .tok       (tok),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop)
   );

   rpn_back #(
      .STACK_DEPTH   (STACK_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .rsp_chan  (rsp_chan)
   );
endmodule

>>> tb/rpn_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_checker
// Watches both channels of the evaluator, keeps its own copy of the operand
// stack and error, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module rpn_checker (
   input  logic        clock,
   input  logic        reset,
   rpn_req_if          req_chan,
   rpn_rsp_if          rsp_chan,
   output int          fail_count,
   output int          pending,
   output int          rsp_count,
   output int          finish_count
);
   import rpn_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  value;
      logic                       finished;
   } answer_type;

   logic signed [VALUE_W-1:0] stack_mem [STACK_DEPTH_DEF];
   int                        depth;
   logic [STATUS_W-1:0]       err_latch;
   answer_type                answers_due [$];

   // signs a wide magnitude and saturates it to 48 bits
   function automatic logic signed [VALUE_W-1:0] clip_mag(logic [127:0] m, bit neg);
      if (neg) begin
         if (m >= 128'h8000_0000_0000) return VALUE_MIN;
         return -$signed(m[VALUE_W-1:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF) return VALUE_MAX;
      return m[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] magnitude(logic signed [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? -v : v;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat_sum(logic signed [VALUE_W:0] s);
      if (s > VALUE_MAX) return VALUE_MAX;
      if (s < VALUE_MIN) return VALUE_MIN;
      return s[VALUE_W-1:0];
   endfunction

   function automatic answer_type evaluate(logic [MODE_W-1:0] mode,
                                           logic signed [VALUE_W-1:0] tok);
      answer_type                a;
      logic signed [VALUE_W-1:0] lhs, rhs, r;
      logic signed [VALUE_W:0]   wide;
      logic [127:0]              prod;
      bit                        neg;
      a.status = ST_OK;
      a.value = '0;
      a.finished = 1'b0;
      if (mode == MODE_FINISH) begin
         a.finished = 1'b1;
         if (err_latch != ST_OK) a.status = err_latch;
         else if (depth == 0) a.status = ST_EMPTY;
         else if (depth > 1) a.status = ST_EXTRA;
         else a.value = stack_mem[0];
         depth = 0;
         err_latch = ST_OK;
         return a;
      end
      if (err_latch == ST_OK) begin
         if (mode == MODE_PUSH) begin
            if (depth >= STACK_DEPTH_DEF) err_latch = ST_OVERFLOW;
            else begin
               stack_mem[depth] = tok;
               depth++;
            end
         end else if (depth < 2) begin
            err_latch = ST_FEW_OPS;
         end else begin
            rhs = stack_mem[depth-1];
            lhs = stack_mem[depth-2];
            neg = lhs[VALUE_W-1] ^ rhs[VALUE_W-1];
            r = '0;
            case (mode)
               MODE_ADD: begin
                  wide = lhs;
                  r = sat_sum(wide + rhs);
               end
               MODE_SUB: begin
                  wide = lhs;
                  r = sat_sum(wide - rhs);
               end
               MODE_MUL: begin
                  prod = 128'(magnitude(lhs)) * 128'(magnitude(rhs));
                  r = clip_mag(prod >> FRACTION_BITS_DEF, neg);
               end
               MODE_DIV: begin
                  if (rhs == 0) err_latch = ST_DIV_ZERO;
                  else begin
                     prod = (128'(magnitude(lhs)) << FRACTION_BITS_DEF)
                            / 128'(magnitude(rhs));
                     r = clip_mag(prod, neg);
                  end
               end
               default: err_latch = ST_UNKNOWN;
            endcase
            if (err_latch == ST_OK) begin
               depth--;
               stack_mem[depth-1] = r;
            end
         end
      end
      a.status = err_latch;
      if (depth > 0) a.value = stack_mem[depth-1];
      return a;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         depth = 0;
         err_latch = ST_OK;
         answers_due.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            answers_due.push_back(evaluate(req_chan.mode, req_chan.token_value));
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (answers_due.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (want.finished) finish_count++;
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  fail_count++;
               end
               if (rsp_chan.result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d", want.value,
                         rsp_chan.result_value);
                  fail_count++;
               end
               if (rsp_chan.finished !== want.finished) begin
                  $error("finished: expected %0d, got %0d", want.finished,
                         rsp_chan.finished);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      rsp_count = 0;
      finish_count = 0;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives classified tokens into the evaluator: directed corner cases, then
// random well-formed expressions mixed with noise, under varying idle and
// stall patterns. The checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import rpn_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
   localparam int ITEM_TARGET  = 850;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, rsp_count, finish_count;
   int   sender_idle_pct, stall_pct;
   int   items_sent;
   int   quiet_cycles = 0;
   logic hold_go;

   rpn_req_if req_chan ();
   rpn_rsp_if rsp_chan ();

   rpn_stack_evaluator_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rpn_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .fail_count   (fail_count),
      .pending      (pending),
      .rsp_count    (rsp_count),
      .finish_count (finish_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return 48'({$urandom, $urandom});
         4: return 48'sd1 <<< $urandom_range(46);
         5: return -(48'sd1 <<< $urandom_range(47));
         default: return 48'($signed($urandom_range(2000)) - 1000) * 48'sd4096
                         + 48'($urandom_range(4095));
      endcase
   endfunction

   task automatic send(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] v);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.token_value <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_expression();
      int to_push, depth;
      to_push = $urandom_range(1, 7);
      depth = 0;
      while (to_push > 0 || depth > 1) begin
         if (depth < 2 || (to_push > 0 && $urandom_range(1))) begin
            send(MODE_PUSH, pick_value());
            to_push--;
            depth++;
         end else begin
            send(3'($urandom_range(MODE_ADD, MODE_DIV)), pick_value());
            depth--;
         end
      end
      send(MODE_FINISH, pick_value());
   endtask

   task automatic random_phase(int idle, int stall, int n, bit squeeze);
      sender_idle_pct = idle;
      stall_pct = stall;
      if (squeeze) hold_go <= 1'b1;
      n += items_sent;
      while (items_sent < n) begin
         case ($urandom_range(49))
            0: begin
               // fill past the top of the stack
               repeat (STACK_DEPTH_DEF + 2) send(MODE_PUSH, pick_value());
               send(MODE_FINISH, pick_value());
            end
            1, 2, 3, 4, 5: send(3'($urandom_range(7)), pick_value());
            6: begin
               send_expression();
               send(MODE_FINISH, pick_value());
            end
            default: send_expression();
         endcase
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_PUSH;
      req_chan.token_value <= '0;
      hold_go <= 1'b0;
      items_sent = 0;
      sender_idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corner cases
      send(MODE_FINISH, '0);               // empty stack
      send(MODE_ADD, '0);                  // too few operands
      send(MODE_FINISH, '0);
      send(MODE_PUSH, VALUE_MAX);
      send(MODE_PUSH, VALUE_MAX);
      send(MODE_ADD, '0);                  // saturates high
      send(MODE_PUSH, VALUE_MIN);
      send(MODE_SUB, '0);                  // max - min saturates
      send(MODE_PUSH, VALUE_MIN);
      send(MODE_MUL, '0);
      send(MODE_PUSH, -48'sd65536);
      send(MODE_DIV, '0);
      send(MODE_FINISH, VALUE_MIN);
      send(MODE_PUSH, 48'sd3);
      send(MODE_PUSH, '0);
      send(MODE_DIV, '0);                  // divide by zero, then sticky
      send(MODE_PUSH, 48'sd5);
      send(MODE_FINISH, '0);
      send(MODE_PUSH, 48'sd1);
      send(MODE_PUSH, -48'sd7);
      send(MODE_BAD, '0);                  // unknown operator
      send(MODE_FINISH, '0);
      send(MODE_PUSH, 48'sd1);
      send(MODE_PUSH, 48'sd2);
      send(MODE_SPARE, VALUE_MIN);
      send(MODE_FINISH, '0);
      send(MODE_PUSH, 48'sd9);
      send(MODE_PUSH, 48'sd9);
      send(MODE_FINISH, '0);               // extra values

      random_phase(0, 0, 220, 1'b1);
      random_phase(80, 0, 200, 1'b0);
      random_phase(0, 80, 200, 1'b0);
      random_phase(24, 24, 200, 1'b0);
      req_chan.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d finished expressions",
               items_sent, rsp_count, finish_count);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
